FILE: rtl/pbd_pkg.sv
// package for the packbits scanline decoder: sizes, phase codes, result record
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package pbd_pkg;

  localparam int MAX_ROW_LENGTH = 1048576;
  localparam int ROW_W          = $clog2(MAX_ROW_LENGTH + 1);
  localparam int CFG_W          = 21;
  localparam int CMP_W          = (ROW_W > CFG_W) ? ROW_W : CFG_W;
  localparam int QDEPTH         = 2;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = $clog2(QDEPTH + 1);

  localparam logic [7:0] HDR_NOP      = 8'h80;
  localparam logic [8:0] REPEAT_BASE  = 9'd257;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2
  } pbd_phase_t;

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] count;
    logic       row_full;
  } pbd_result_t;

endpackage
`default_nettype wire

FILE: rtl/pbd_front.sv
// front end: accepts compressed bytes, tracks header phase and row fill,
// and pushes clipped run results into the queue; uses pbd_pkg
`timescale 1ns / 1ps
`default_nettype none
module pbd_front (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  input  wire  [7:0]                in_byte,
  input  wire                       in_last,
  output logic                      in_ready,
  input  wire  [pbd_pkg::CFG_W-1:0] row_length,
  input  wire                       q_space,
  output logic                      push,
  output pbd_pkg::pbd_result_t      result
);
  import pbd_pkg::*;

  pbd_phase_t       phase_r, phase_nxt;
  logic [6:0]       literal_left_r, literal_left_nxt;
  logic [7:0]       repeat_length_r, repeat_length_nxt;
  logic [ROW_W-1:0] row_written_r, row_written_nxt;

  logic             acc;
  logic [CMP_W-1:0] cfg_ext;
  logic [CMP_W-1:0] len_ext;
  logic [ROW_W-1:0] len;
  logic [ROW_W-1:0] room;
  logic [7:0]       cnt;
  logic [ROW_W-1:0] written_add;
  logic             produce;

  assign in_ready = q_space;
  assign acc      = in_valid && q_space;

  always_comb begin
    cfg_ext = CMP_W'(row_length);
    len_ext = (cfg_ext > CMP_W'(MAX_ROW_LENGTH)) ? CMP_W'(MAX_ROW_LENGTH) : cfg_ext;
    len     = ROW_W'(len_ext);
    room    = len - row_written_r;
    cnt     = (ROW_W'(repeat_length_r) > room) ? room[7:0] : repeat_length_r;
  end

  always_comb begin
    phase_nxt         = phase_r;
    literal_left_nxt  = literal_left_r;
    repeat_length_nxt = repeat_length_r;
    row_written_nxt   = row_written_r;
    produce           = 1'b0;
    written_add       = row_written_r;
    result.value      = in_byte;
    result.count      = 8'd1;
    result.row_full   = 1'b0;
    if (acc) begin
      if (row_written_r < len) begin
        unique case (phase_r)
          PH_HEADER: begin
            if (!in_byte[7]) begin
              literal_left_nxt = in_byte[6:0];
              phase_nxt        = PH_LITERAL;
            end else if (in_byte != HDR_NOP) begin
              repeat_length_nxt = 8'(REPEAT_BASE - {1'b0, in_byte});
              phase_nxt         = PH_REPEAT;
            end
          end
          PH_LITERAL: begin
            written_add     = row_written_r + ROW_W'(1);
            row_written_nxt = written_add;
            result.count    = 8'd1;
            result.row_full = (written_add == len);
            produce         = 1'b1;
            if (literal_left_r == 7'd0) begin
              phase_nxt = PH_HEADER;
            end else begin
              literal_left_nxt = literal_left_r - 7'd1;
            end
          end
          PH_REPEAT: begin
            written_add     = row_written_r + ROW_W'(cnt);
            row_written_nxt = written_add;
            result.count    = cnt;
            result.row_full = (written_add == len);
            produce         = 1'b1;
            phase_nxt       = PH_HEADER;
          end
          default: begin
            phase_nxt = PH_HEADER;
          end
        endcase
      end
      if (in_last) begin
        phase_nxt         = PH_HEADER;
        literal_left_nxt  = 7'd0;
        repeat_length_nxt = 8'd0;
        row_written_nxt   = '0;
      end
    end
  end

  assign push = produce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HEADER;
      literal_left_r  <= 7'd0;
      repeat_length_r <= 8'd0;
      row_written_r   <= '0;
    end else begin
      phase_r         <= phase_nxt;
      literal_left_r  <= literal_left_nxt;
      repeat_length_r <= repeat_length_nxt;
      row_written_r   <= row_written_nxt;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last |=> phase_r == PH_HEADER && row_written_r == '0)
    else $error("scanline end did not clear state");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> result.count != 8'd0)
    else $error("run result with zero count");

  a_literal_single: assert property (@(posedge clk) disable iff (!rst_n)
    push && phase_r == PH_LITERAL |-> result.count == 8'd1)
    else $error("literal byte with count other than one");

endmodule
`default_nettype wire

FILE: rtl/pbd_queue.sv
// back end queue: two-entry register fifo holding run results until taken
// uses pbd_pkg for the result record and depth
`timescale 1ns / 1ps
`default_nettype none
module pbd_queue (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        push,
  input  wire pbd_pkg::pbd_result_t  push_data,
  output logic                       space,
  input  wire                        pop,
  output logic                       head_valid,
  output pbd_pkg::pbd_result_t       head_data
);
  import pbd_pkg::*;

  pbd_result_t       mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign space      = (cnt_r != QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    priority if (push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> space)
    else $error("push into full queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue fill count out of range");

  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !do_pop |=> cnt_r == $past(cnt_r) + QCNT_W'(1))
    else $error("queue fill count did not grow on push");

endmodule
`default_nettype wire

FILE: rtl/packbits_scanline_decoder.sv
// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready  tdata[7:0] code_byte, tlast scanline_end
// out_     out  out_tvalid/out_tready tdata[7:0] value, [15:8] count, tlast row_full
// cfg_     in   cfg_valid/cfg_ready  cfg_data[20:0] row_length
//
// one compressed byte per cycle while the queue has space; each run result is registered in the result queue
// the front updates its header/row state registers on each accepted byte, the queue decouples stalls
// a two-entry result queue keeps input flowing while out_tready is low, until the queue fills
// reset: synchronous active low, row_length returns to 1, no clearing pass
// top level of the packbits scanline decoder; uses pbd_pkg, pbd_front, pbd_queue
`timescale 1ns / 1ps
`default_nettype none
module packbits_scanline_decoder (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  input  wire  [7:0]                 in_tdata,   // code_byte
  input  wire                        in_tlast,   // scanline_end
  output logic                       out_tvalid,
  input  wire                        out_tready,
  output logic [15:0]                out_tdata,  // value, count
  output logic                       out_tlast,  // row_full
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire  [pbd_pkg::CFG_W-1:0]  cfg_data    // row_length
);
  import pbd_pkg::*;

  logic [CFG_W-1:0] row_length_r;
  logic             q_space;
  logic             push;
  pbd_result_t      push_data;
  pbd_result_t      head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= CFG_W'(1);
    end else if (cfg_valid) begin
      row_length_r <= cfg_data;
    end
  end

  pbd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .in_ready   (in_tready),
    .row_length (row_length_r),
    .q_space    (q_space),
    .push       (push),
    .result     (push_data)
  );

  pbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .space      (q_space),
    .pop        (out_tready),
    .head_valid (out_tvalid),
    .head_data  (head)
  );

  assign out_tdata = {head.count, head.value};
  assign out_tlast = head.row_full;

endmodule
`default_nettype wire
